### hdl/stlb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared constants, item kind codes and controller command type for the TLB.
// ----------------------------------------------------------------------------
package stlb_pkg;

	localparam int unsigned SETS_DEF             = 16;
	localparam int unsigned WAYS_DEF             = 4;
	localparam int unsigned PAGE_OFFSET_BITS_DEF = 12;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned RANK_W = 3;

	localparam logic [KIND_W-1:0] KIND_XLATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage
`default_nettype wire

### hdl/stlb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stlb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### hdl/stlb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_ctrl
// Controller: takes an item, waits for the set read, commits and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module stlb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output stlb_pkg::cmd_t     cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_LOOK = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == S_LOOK) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.capture) state_q <= S_LOOK;
				S_LOOK: if (cmd.commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/stlb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stlb_dp
// Datapath: item registers, valid bits, set RAM, parallel tag compare, LRU
// rank update and the result register.
// ----------------------------------------------------------------------------
module stlb_dp #(
	parameter int unsigned SETS             = stlb_pkg::SETS_DEF,
	parameter int unsigned WAYS             = stlb_pkg::WAYS_DEF,
	parameter int unsigned PAGE_OFFSET_BITS = stlb_pkg::PAGE_OFFSET_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stlb_pkg::cmd_t                cmd,
	input  wire logic [stlb_pkg::KIND_W-1:0]   kind,
	input  wire logic [stlb_pkg::ADDR_W-1:0]   va,
	input  wire logic [stlb_pkg::ADDR_W-1:0]   walk_page_base,
	input  wire logic                          walk_fault,
	output logic      [stlb_pkg::ADDR_W-1:0]   pa,
	output logic                               hit,
	output logic                               fault,
	output logic      [stlb_pkg::RANK_W-1:0]   rank
);

	localparam int unsigned AW       = stlb_pkg::ADDR_W;
	localparam int unsigned SET_BITS = $clog2(SETS);
	localparam int unsigned SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int unsigned FRM_W    = AW - PAGE_OFFSET_BITS;
	localparam int unsigned TAG_W    = FRM_W - SET_BITS;
	localparam int unsigned RNK_W    = $clog2(WAYS + 1);
	localparam int unsigned WAY_W    = TAG_W + FRM_W + RNK_W;
	localparam int unsigned ROW_W    = WAYS * WAY_W;
	localparam int unsigned WAY_IW   = $clog2(WAYS);

	logic [stlb_pkg::KIND_W-1:0] kind_q;
	logic [AW-1:0]               va_q;
	logic [AW-1:0]               base_q;
	logic                        wfault_q;
	logic [WAYS-1:0]             valid_q [SETS];

	logic [SET_IW-1:0] rd_set;
	logic [SET_IW-1:0] set_q;
	logic [TAG_W-1:0]  tag_in;
	logic [FRM_W-1:0]  frm_in;
	logic [ROW_W-1:0]  row_rd;
	logic [ROW_W-1:0]  row_wr;
	logic              row_we;

	logic [TAG_W-1:0]  w_tag [WAYS];
	logic [FRM_W-1:0]  w_frm [WAYS];
	logic [RNK_W-1:0]  w_rnk [WAYS];
	logic [RNK_W-1:0]  n_rnk [WAYS];
	logic [WAYS-1:0]   w_val;
	logic [WAYS-1:0]   match;
	logic              any_hit;
	logic [WAY_IW-1:0] hw;
	logic [WAY_IW-1:0] victim;
	logic [AW-1:0]     pa_n;
	logic              hit_n;
	logic              fault_n;
	logic [stlb_pkg::RANK_W-1:0] rank_n;

	assign rd_set = SET_IW'((va >> PAGE_OFFSET_BITS) & AW'(SETS - 1));
	assign set_q  = SET_IW'((va_q >> PAGE_OFFSET_BITS) & AW'(SETS - 1));
	assign tag_in = TAG_W'(va_q >> (PAGE_OFFSET_BITS + SET_BITS));
	assign frm_in = base_q[AW-1:PAGE_OFFSET_BITS];
	assign w_val  = valid_q[set_q];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			va_q     <= va;
			base_q   <= walk_page_base;
			wfault_q <= walk_fault;
		end
		if (cmd.commit) begin
			pa    <= pa_n;
			hit   <= hit_n;
			fault <= fault_n;
			rank  <= rank_n;
		end
	end

	stlb_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_ram (
		.clk    (clk),
		.wr_en  (row_we),
		.wr_addr(set_q),
		.wr_data(row_wr),
		.rd_en  (cmd.capture),
		.rd_addr(rd_set),
		.rd_data(row_rd)
	);

	always_comb begin
		logic            found0;
		logic [RNK_W-1:0] best;
		for (int i = 0; i < WAYS; i++) begin
			{w_tag[i], w_frm[i], w_rnk[i]} = row_rd[i*WAY_W +: WAY_W];
			if (!w_val[i]) w_rnk[i] = '0;
			match[i] = w_val[i] && (w_tag[i] == tag_in);
		end
		any_hit = |match;
		hw = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) hw = WAY_IW'(i);
		end
		victim = '0;
		found0 = 1'b0;
		best   = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found0) begin
				if (w_rnk[i] == '0) begin
					victim = WAY_IW'(i);
					found0 = 1'b1;
				end else if (w_rnk[i] > best) begin
					best   = w_rnk[i];
					victim = WAY_IW'(i);
				end
			end
		end
		row_wr = row_rd;
		for (int i = 0; i < WAYS; i++) begin
			n_rnk[i] = w_rnk[i];
			if (any_hit) begin
				if (WAY_IW'(i) == hw) n_rnk[i] = RNK_W'(1);
				else if (w_val[i] && w_rnk[i] < w_rnk[hw]) n_rnk[i] = w_rnk[i] + 1'b1;
				row_wr[i*WAY_W +: WAY_W] = {w_tag[i], w_frm[i], n_rnk[i]};
			end else begin
				if (WAY_IW'(i) == victim) begin
					row_wr[i*WAY_W +: WAY_W] = {tag_in, frm_in, RNK_W'(1)};
				end else begin
					if (w_val[i]) n_rnk[i] = w_rnk[i] + 1'b1;
					row_wr[i*WAY_W +: WAY_W] = {w_tag[i], w_frm[i], n_rnk[i]};
				end
			end
		end
		pa_n    = '0;
		hit_n   = 1'b0;
		fault_n = 1'b0;
		rank_n  = '0;
		row_we  = 1'b0;
		unique case (kind_q)
			stlb_pkg::KIND_XLATE: begin
				if (any_hit) begin
					pa_n   = {w_frm[hw], va_q[PAGE_OFFSET_BITS-1:0]};
					hit_n  = 1'b1;
					row_we = cmd.commit;
				end else if (wfault_q) begin
					fault_n = 1'b1;
				end else begin
					pa_n   = {frm_in, va_q[PAGE_OFFSET_BITS-1:0]};
					row_we = cmd.commit;
				end
			end
			stlb_pkg::KIND_PEEK: begin
				hit_n  = any_hit;
				rank_n = any_hit ? stlb_pkg::RANK_W'(w_rnk[hw]) : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) valid_q[s] <= '0;
		end else if (cmd.commit) begin
			if (kind_q == stlb_pkg::KIND_FLUSH) begin
				for (int s = 0; s < SETS; s++) valid_q[s] <= '0;
			end else if (kind_q == stlb_pkg::KIND_XLATE && !any_hit && !wfault_q) begin
				valid_q[set_q][victim] <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/set_assoc_tlb_lru_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru_unit
// Set-associative TLB with rank-based LRU replacement.
// ----------------------------------------------------------------------------
// One item at a time. The input transfer edge captures the item and reads the
// set row from the set RAM, which holds all ways of a set in one row. The commit
// edge, which waits until the output register is free, compares tags, writes the
// updated row and loads the result register. A further transfer is taken only
// after that commit, so an item is not accepted while another is in flight. A new
// item is taken while the previous result waits at the output. It then holds
// in the compare step until the output frees. SETS must be a power of two.
// Valid bits are flip-flops, so no clearing pass is needed after reset, and a
// flush clears them all when it commits.
module set_assoc_tlb_lru_unit #(
	parameter int unsigned SETS             = stlb_pkg::SETS_DEF,
	parameter int unsigned WAYS             = stlb_pkg::WAYS_DEF,
	parameter int unsigned PAGE_OFFSET_BITS = stlb_pkg::PAGE_OFFSET_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [stlb_pkg::KIND_W-1:0] kind,
	input  wire logic [stlb_pkg::ADDR_W-1:0] va,
	input  wire logic [stlb_pkg::ADDR_W-1:0] walk_page_base,
	input  wire logic                        walk_fault,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [stlb_pkg::ADDR_W-1:0] pa,
	output logic                             hit,
	output logic                             fault,
	output logic      [stlb_pkg::RANK_W-1:0] rank
);

	stlb_pkg::cmd_t cmd;

	stlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	stlb_dp #(
		.SETS            (SETS),
		.WAYS            (WAYS),
		.PAGE_OFFSET_BITS(PAGE_OFFSET_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.va            (va),
		.walk_page_base(walk_page_base),
		.walk_fault    (walk_fault),
		.pa            (pa),
		.hit           (hit),
		.fault         (fault),
		.rank          (rank)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transfer taken while an item is in flight");

	a_hit_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && fault))
		else $error("hit and fault together");

	a_fault_pa_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> pa == '0)
		else $error("nonzero pa on fault");

	a_rank_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rank != '0 |-> hit)
		else $error("rank without hit");

endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for set_assoc_tlb_lru_unit: directed and random
// translate, peek and flush traffic, checked against a rank-LRU TLB predictor.
// ----------------------------------------------------------------------------
module tb;
	import stlb_pkg::*;

	localparam int NSETS = SETS_DEF;
	localparam int NWAYS = WAYS_DEF;
	localparam int POB   = PAGE_OFFSET_BITS_DEF;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] pa;
		logic              hit;
		logic              fault;
		logic [RANK_W-1:0] rank;
	} xlate_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = '0;
	logic [ADDR_W-1:0] va = '0;
	logic [ADDR_W-1:0] walk_page_base = '0;
	logic walk_fault = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ADDR_W-1:0] pa;
	logic hit, fault;
	logic [RANK_W-1:0] rank;

	set_assoc_tlb_lru_unit i_dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic        tlb_valid [NSETS][NWAYS];
	logic [47:0] tlb_tag   [NSETS][NWAYS];
	logic [51:0] tlb_frame [NSETS][NWAYS];
	int unsigned tlb_rank  [NSETS][NWAYS];

	xlate_res_t expected_q[$];
	int errors = 0;
	int n_xfers = 0, n_results = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 0;
	logic [ADDR_W-1:0] hot_va[8];

	task automatic report(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic void pred_wipe();
		foreach (tlb_valid[s, w]) begin
			tlb_valid[s][w] = 0; tlb_tag[s][w] = 0;
			tlb_frame[s][w] = 0; tlb_rank[s][w] = 0;
		end
	endfunction

	function automatic xlate_res_t tlb_predict(input logic [KIND_W-1:0] k,
			input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] pbase,
			input logic flt);
		xlate_res_t r;
		logic [51:0] vpn;
		int s, hw, victim, best, old;
		logic [47:0] tg;
		r = '0;
		vpn = a >> POB;
		s = vpn % NSETS;
		tg = vpn / NSETS;
		hw = -1;
		for (int w = NWAYS - 1; w >= 0; w--)
			if (tlb_valid[s][w] && tlb_tag[s][w] == tg) hw = w;
		if (k == KIND_FLUSH) begin
			pred_wipe();
		end else if (k == KIND_PEEK) begin
			if (hw >= 0) begin
				r.hit = 1; r.rank = tlb_rank[s][hw][RANK_W-1:0];
			end
		end else if (k == KIND_XLATE) begin
			if (hw >= 0) begin
				old = tlb_rank[s][hw];
				for (int w = 0; w < NWAYS; w++)
					if (w != hw && tlb_valid[s][w] && tlb_rank[s][w] < old)
						tlb_rank[s][w]++;
				tlb_rank[s][hw] = 1;
				r.pa = {tlb_frame[s][hw], a[POB-1:0]};
				r.hit = 1;
			end else if (flt) begin
				r.fault = 1;
			end else begin
				victim = 0; best = -1;
				for (int w = 0; w < NWAYS; w++) begin
					if (tlb_rank[s][w] == 0) begin
						victim = w; break;
					end
					if (int'(tlb_rank[s][w]) > best) begin
						best = tlb_rank[s][w]; victim = w;
					end
				end
				for (int w = 0; w < NWAYS; w++)
					if (w != victim && tlb_valid[s][w] && tlb_rank[s][w] < 255)
						tlb_rank[s][w]++;
				tlb_valid[s][victim] = 1;
				tlb_tag[s][victim] = tg;
				tlb_frame[s][victim] = pbase >> POB;
				tlb_rank[s][victim] = 1;
				r.pa = {tlb_frame[s][victim], a[POB-1:0]};
			end
		end
		return r;
	endfunction

	// valid stays high between back-to-back items; it drops only while idling
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] pbase, input logic flt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; kind <= k; va <= a; walk_page_base <= pbase; walk_fault <= flt;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(tlb_predict(k, a, pbase, flt));
		n_xfers++;
	endtask

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// address near a small pool so sets fill, hit and evict
	function automatic logic [ADDR_W-1:0] pick_va();
		logic [ADDR_W-1:0] a;
		a = hot_va[$urandom_range(7)];
		a[POB+3:POB] = $urandom_range(3);
		a[POB+5:POB+4] = $urandom_range(3);
		a[POB-1:0] = $urandom;
		return a;
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			xlate_res_t e;
			n_results++;
			if (expected_q.size() == 0) begin
				report("unexpected transfer", pa, 0);
			end else begin
				e = expected_q.pop_front();
				if (pa !== e.pa) report("pa", pa, e.pa);
				if (hit !== e.hit) report("hit", hit, e.hit);
				if (fault !== e.fault) report("fault", fault, e.fault);
				if (rank !== e.rank) report("rank", rank, e.rank);
			end
		end
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic test_directed();
		logic [ADDR_W-1:0] a;
		send_item(KIND_XLATE, '0, '1, 0);
		send_item(KIND_XLATE, '1, '1, 0);
		send_item(KIND_XLATE, '1, '0, 1);
		send_item(KIND_PEEK, '1, '0, 0);
		send_item(KIND_PEEK, 64'h5000, '1, 1);
		// fill one set past capacity, then touch and peek
		for (int i = 0; i < 6; i++) begin
			a = (64'(i) << (POB + 4)) | 64'h3abc;
			send_item(KIND_XLATE, a, 64'(i) << 20 | 64'hfff, 0);
		end
		send_item(KIND_XLATE, (64'd3 << (POB + 4)) | 64'h3001, '1, 1);
		for (int i = 0; i < 6; i++)
			send_item(KIND_PEEK, (64'(i) << (POB + 4)) | 64'h3000, '0, 0);
		send_item(KIND_XLATE, 64'h7123, 64'h9000, 1);
		send_item(KIND_NONE, 64'h3abc, '1, 0);
		send_item(KIND_FLUSH, '1, '1, 1);
		send_item(KIND_PEEK, '1, '0, 0);
		drain();
	endtask

	task automatic test_random(input int n, input int idle, input int stall);
		int r;
		send_idle_pct = idle; recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 60)
				send_item(KIND_XLATE, pick_va(), rand64(), $urandom_range(9) == 0);
			else if (r < 70)
				send_item(KIND_XLATE, rand64(), rand64(), $urandom_range(1));
			else if (r < 93)
				send_item(KIND_PEEK, pick_va(), rand64(), $urandom_range(1));
			else if (r < 97)
				send_item(KIND_NONE, rand64(), rand64(), $urandom_range(1));
			else
				send_item(KIND_FLUSH, rand64(), rand64(), $urandom_range(1));
		end
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_off = 1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++)
				send_item(KIND_XLATE, pick_va(), rand64(), 0);
		join
		drain();
	endtask

	initial begin
		pred_wipe();
		foreach (hot_va[i]) hot_va[i] = rand64();
		hot_va[0] = '0; hot_va[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(350, 0, 0);
		test_random(350, 67, 0);
		test_random(350, 0, 67);
		test_random(350, 36, 36);
		test_backpressure();
		$display("covered %0d transfers in, %0d results: translate hit/miss/fault,", n_xfers,
			n_results);
		$display("peek, flush, unused kind, eviction, idle and stall phases, long hold-off");
		if (errors == 0 && expected_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end
endmodule

### set_assoc_tlb_lru_unit.f
hdl/stlb_pkg.sv
hdl/stlb_ram.sv
hdl/stlb_ctrl.sv
hdl/stlb_dp.sv
hdl/set_assoc_tlb_lru_unit.sv
tb/sv/tb.sv
